### rtl/obb_pkg.sv
`timescale 1ns / 1ps

package obb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W = 32 + FRAC_BITS;

    localparam logic [2:0] KIND_CENTER = 3'd0;
    localparam logic [2:0] KIND_AXIS0  = 3'd1;
    localparam logic [2:0] KIND_AXIS1  = 3'd2;
    localparam logic [2:0] KIND_AXIS2  = 3'd3;
    localparam logic [2:0] KIND_HALF   = 3'd4;

    localparam logic OPC_LOAD    = 1'b0;
    localparam logic OPC_CONVERT = 1'b1;

    localparam logic [1:0] MDU_MUL  = 2'd0;
    localparam logic [1:0] MDU_DIV  = 2'd1;
    localparam logic [1:0] MDU_SQRT = 2'd2;

    localparam logic signed [66:0] SAT_MAX = 67'sh7FFFFFFF;
    localparam logic signed [66:0] SAT_MIN = -67'sh80000000;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         column_index;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } req_t;

    typedef struct packed {
        logic [2:0]         vector_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               last_vector;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [32:0] b;
    } mdu_req_t;

    // Magnitude of a signed word; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [66:0] v);
        if (v > SAT_MAX) begin
            return 32'h7FFFFFFF;
        end
        else if (v < SAT_MIN) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Transform storage is kept column by column, three rows each.
    function automatic logic [3:0] cidx(input logic [1:0] col, input logic [1:0] row);
        return {col, 2'b00} - {2'b00, col} + {2'b00, row};
    endfunction

endpackage

### rtl/obb_mdu.sv
`timescale 1ns / 1ps

module obb_mdu (
    input  logic               clk,
    input  logic               rst_n,
    input  obb_pkg::mdu_req_t  req,
    output logic               done,
    output logic [64:0]        result
);
    import obb_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  op_reg;
    logic [64:0] acc_reg;
    logic [64:0] x_reg;
    logic [32:0] y_reg;

    logic [64:0] acc_next;
    logic [64:0] x_next;
    logic [32:0] y_next;
    logic [32:0] div_rem;
    logic [34:0] sq_rem;
    logic [34:0] sq_trial;
    logic        div_bit;

    // One result bit per cycle: shift-add multiply, restoring divide and
    // digit-by-digit square root all share the same three shift registers.
    always_comb
    begin
        div_rem  = {acc_reg[31:0], x_reg[DIV_W-1]};
        div_bit  = (div_rem >= y_reg);
        sq_rem   = {acc_reg[32:0], x_reg[63:62]};
        sq_trial = {y_reg, 2'b01};
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        unique case (op_reg)
            MDU_MUL:
            begin
                acc_next = y_reg[0] ? acc_reg + x_reg : acc_reg;
                x_next   = {x_reg[63:0], 1'b0};
                y_next   = {1'b0, y_reg[32:1]};
            end
            MDU_DIV:
            begin
                acc_next = {32'd0, div_bit ? div_rem - y_reg : div_rem};
                x_next   = {x_reg[63:0], div_bit};
            end
            MDU_SQRT:
            begin
                if (sq_rem >= sq_trial)
                begin
                    acc_next = {30'd0, sq_rem - sq_trial};
                    y_next   = {y_reg[31:0], 1'b1};
                end
                else
                begin
                    acc_next = {30'd0, sq_rem};
                    y_next   = {y_reg[31:0], 1'b0};
                end
                x_next = {x_reg[62:0], 2'b00};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= MDU_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == MDU_DIV) ? 6'(DIV_W - 1) : 6'd31;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            acc_reg <= '0;
            x_reg   <= {1'b0, req.a};
            y_reg   <= (req.op == MDU_SQRT) ? '0 : req.b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        unique case (op_reg)
            MDU_DIV:  result = {{(65 - DIV_W){1'b0}}, x_reg[DIV_W-1:0]};
            MDU_SQRT: result = {32'd0, y_reg};
            default:  result = acc_reg;
        endcase
    end

endmodule

### rtl/oriented_box_from_transformed_box.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  obb_pkg::req_t (load column or convert box)
// res      out        res_valid/res_stall  obb_pkg::res_t (center, three axes, half sizes)
//
// A column load is written straight into the transform. A box conversion runs
// one request at a time through a single bit-serial unit: 21 multiplies, 3 square
// roots and up to 9 divides, after which the center rows are finished and the
// vectors emitted one by one. A zero-length column skips its three divides.
// Reset clears the transform to zero and empties the output register.
// A stall on res holds the finished vector and pauses the sequence.
module oriented_box_from_transformed_box (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  obb_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output obb_pkg::res_t res
);
    import obb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_CEN  = 3'd3;
    localparam logic [2:0] S_CFIN = 3'd4;
    localparam logic [2:0] S_AX   = 3'd5;
    localparam logic [2:0] S_HALF = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]         state_reg;
    logic               issued_reg;
    logic [1:0]         i_reg;
    logic [1:0]         j_reg;
    logic [2:0]         kind_reg;
    logic signed [31:0] cols_reg [0:11];
    logic signed [31:0] c_reg [0:2];
    logic signed [32:0] d_reg [0:2];
    logic [31:0]        s_reg [0:2];
    logic signed [31:0] vbuf_reg [0:2];
    logic signed [66:0] acc_reg;
    logic               res_valid_reg;
    res_t               res_reg;

    mdu_req_t           mdu_req;
    logic               mdu_done;
    logic [64:0]        mdu_result;

    logic signed [31:0] m_sel;
    logic [1:0]         sel_col;
    logic               accept;
    logic               load_ok;
    logic [32:0]        sum_x;
    logic [32:0]        sum_y;
    logic [32:0]        sum_z;
    logic signed [66:0] prod_s;
    logic               prod_neg;
    logic signed [66:0] center_r;
    logic [47:0]        half_p;

    obb_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mdu_req),
        .done   (mdu_done),
        .result (mdu_result)
    );

    // Only one transform word is read at a time; the translation column is
    // selected while a center row is being finished.
    assign sel_col = (state_reg == S_CFIN) ? 2'd3 : j_reg;
    assign m_sel   = cols_reg[cidx(sel_col, i_reg)];

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load_ok   = !res_valid_reg || !res_stall;

    // Sums of box minimum and maximum; dropping the low bit gives the
    // center rounded toward minus infinity.
    assign sum_x = {req.first_x[31], req.first_x} + {req.second_x[31], req.second_x};
    assign sum_y = {req.first_y[31], req.first_y} + {req.second_y[31], req.second_y};
    assign sum_z = {req.first_z[31], req.first_z} + {req.second_z[31], req.second_z};

    always_comb
    begin
        mdu_req.start = 1'b0;
        mdu_req.op    = MDU_MUL;
        mdu_req.a     = {32'd0, mag32(m_sel)};
        mdu_req.b     = {1'b0, mag32(m_sel)};
        prod_neg      = 1'b0;
        case (state_reg)
            S_LEN:
            begin
                mdu_req.start = !issued_reg;
            end
            S_SQRT:
            begin
                mdu_req.start = !issued_reg;
                mdu_req.op    = MDU_SQRT;
                mdu_req.a     = acc_reg[63:0];
            end
            S_CEN:
            begin
                mdu_req.start = !issued_reg;
                mdu_req.b     = {1'b0, mag32(c_reg[j_reg])};
                prod_neg      = m_sel[31] ^ c_reg[j_reg][31];
            end
            S_AX:
            begin
                mdu_req.start = !issued_reg && (s_reg[j_reg] != '0);
                mdu_req.op    = MDU_DIV;
                mdu_req.a     = 64'(mag32(m_sel)) << FRAC_BITS;
                mdu_req.b     = {1'b0, s_reg[j_reg]};
                prod_neg      = m_sel[31];
            end
            S_HALF:
            begin
                mdu_req.start = !issued_reg;
                mdu_req.a     = 64'(d_reg[i_reg][32] ? 33'(-d_reg[i_reg]) : 33'(d_reg[i_reg]));
                mdu_req.b     = {1'b0, s_reg[i_reg]};
                prod_neg      = d_reg[i_reg][32];
            end
            default:
            begin
                mdu_req.start = 1'b0;
            end
        endcase
    end

    // Products and quotients arrive as magnitudes; the sign is put back here.
    assign prod_s   = prod_neg ? -signed'({2'b00, mdu_result}) : signed'({2'b00, mdu_result});
    assign center_r = (acc_reg >>> FRAC_BITS) + 67'(m_sel);
    assign half_p   = 48'(mdu_result >> (FRAC_BITS + 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            kind_reg      <= KIND_CENTER;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 12; k++)
            begin
                cols_reg[k] <= '0;
            end
        end
        else
        begin
            // A vector is loaded when the output register is free or is
            // being emptied in this very cycle.
            if (state_reg == S_EMIT && load_ok)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (mdu_req.start)
            begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.opcode == OPC_LOAD)
                        begin
                            cols_reg[cidx(req.column_index, 2'd0)] <= req.first_x;
                            cols_reg[cidx(req.column_index, 2'd1)] <= req.first_y;
                            cols_reg[cidx(req.column_index, 2'd2)] <= req.first_z;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= S_LEN;
                        end
                    end
                end
                S_LEN:
                begin
                    if (mdu_done)
                    begin
                        issued_reg <= 1'b0;
                        if (i_reg == 2'd2)
                        begin
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (mdu_done)
                    begin
                        issued_reg <= 1'b0;
                        i_reg      <= '0;
                        if (j_reg == 2'd2)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_CEN;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_LEN;
                        end
                    end
                end
                S_CEN:
                begin
                    if (mdu_done)
                    begin
                        issued_reg <= 1'b0;
                        if (j_reg == 2'd2)
                        begin
                            state_reg <= S_CFIN;
                        end
                        else
                        begin
                            j_reg <= j_reg + 2'd1;
                        end
                    end
                end
                S_CFIN:
                begin
                    j_reg <= '0;
                    if (i_reg == 2'd2)
                    begin
                        i_reg     <= '0;
                        kind_reg  <= KIND_CENTER;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 2'd1;
                        state_reg <= S_CEN;
                    end
                end
                S_AX:
                begin
                    if (mdu_done || s_reg[j_reg] == '0)
                    begin
                        issued_reg <= 1'b0;
                        if (i_reg == 2'd2)
                        begin
                            i_reg     <= '0;
                            kind_reg  <= KIND_AXIS0 + {1'b0, j_reg};
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                end
                S_HALF:
                begin
                    if (mdu_done)
                    begin
                        issued_reg <= 1'b0;
                        if (i_reg == 2'd2)
                        begin
                            i_reg     <= '0;
                            kind_reg  <= KIND_HALF;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (load_ok)
                    begin
                        unique case (kind_reg) inside
                            KIND_CENTER:
                            begin
                                j_reg     <= '0;
                                state_reg <= S_AX;
                            end
                            KIND_AXIS0, KIND_AXIS1:
                            begin
                                j_reg     <= j_reg + 2'd1;
                                state_reg <= S_AX;
                            end
                            KIND_AXIS2:
                            begin
                                state_reg <= S_HALF;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: box center, box extent, column lengths, the vector
    // being assembled, and the accumulator for sums of products.
    always_ff @(posedge clk)
    begin
        if (accept && req.opcode == OPC_CONVERT)
        begin
            c_reg[0] <= sum_x[32:1];
            c_reg[1] <= sum_y[32:1];
            c_reg[2] <= sum_z[32:1];
            d_reg[0] <= {req.second_x[31], req.second_x} - {req.first_x[31], req.first_x};
            d_reg[1] <= {req.second_y[31], req.second_y} - {req.first_y[31], req.first_y};
            d_reg[2] <= {req.second_z[31], req.second_z} - {req.first_z[31], req.first_z};
            acc_reg  <= '0;
        end
        case (state_reg)
            S_LEN, S_CEN:
            begin
                if (mdu_done)
                begin
                    acc_reg <= acc_reg + prod_s;
                end
            end
            S_SQRT:
            begin
                if (mdu_done)
                begin
                    s_reg[j_reg] <= mdu_result[31:0];
                    acc_reg      <= '0;
                end
            end
            S_CFIN:
            begin
                vbuf_reg[i_reg] <= sat32(center_r);
                acc_reg         <= '0;
            end
            S_AX:
            begin
                if (s_reg[j_reg] == '0)
                begin
                    vbuf_reg[i_reg] <= (i_reg == j_reg) ? 32'(1) << FRAC_BITS : '0;
                end
                else if (mdu_done)
                begin
                    vbuf_reg[i_reg] <= sat32(prod_s);
                end
            end
            S_HALF:
            begin
                if (mdu_done)
                begin
                    vbuf_reg[i_reg] <= sat32(prod_neg ? -signed'({19'd0, half_p})
                                                      : signed'({19'd0, half_p}));
                end
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    res_reg.vector_kind <= kind_reg;
                    res_reg.out_x       <= vbuf_reg[0];
                    res_reg.out_y       <= vbuf_reg[1];
                    res_reg.out_z       <= vbuf_reg[2];
                    res_reg.last_vector <= (kind_reg == KIND_HALF);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTH
    // The run marker goes only with the half-size vector.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last_vector == (res.vector_kind == KIND_HALF)))
        else $error("last_vector does not match vector_kind");

    // The serial unit finishes only while a conversion is running.
    a_mdu_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT) |-> !mdu_done)
        else $error("arithmetic unit finished outside a conversion");

    // A new vector is loaded only after the previous one has gone.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> $stable(res))
        else $error("output overwritten while stalled");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import obb_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  res_valid;
    logic  res_stall;
    res_t  res;

    // Idle percentages for the sender and the receiver, changed per phase.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Predictor state: the transform as the block should hold it.
    logic signed [31:0] xform [12];

    // Vectors the block still owes us, oldest first.
    res_t pending_vectors [$];

    int unsigned error_count;
    int unsigned vectors_checked;
    int unsigned requests_sent;
    longint unsigned cycle_count;

    localparam longint unsigned CYCLE_LIMIT = 4000000;

    oriented_box_from_transformed_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // The run is cut off if the block hangs somewhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver stalls at random, at the phase's rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Saturate a wide signed value to the 32-bit output range.
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -128'sh80000000)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Floor square root by the digit-by-digit method.
    function automatic logic [63:0] floor_sqrt(input logic [65:0] v);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] bitv;
        rem = v;
        root = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[63:0];
    endfunction

    // Work out the five vectors of one box conversion and queue them.
    task automatic predict_box(input req_t r);
        logic signed [127:0] lo [3];
        logic signed [127:0] hi [3];
        logic signed [127:0] mid [3];
        logic signed [127:0] acc;
        logic signed [127:0] d;
        logic signed [127:0] e;
        logic [127:0] sq;
        logic [127:0] q;
        logic [63:0] len [3];
        logic signed [31:0] comp [3];
        res_t v;
        lo[0] = r.first_x;  lo[1] = r.first_y;  lo[2] = r.first_z;
        hi[0] = r.second_x; hi[1] = r.second_y; hi[2] = r.second_z;
        for (int i = 0; i < 3; i++)
        begin
            mid[i] = (lo[i] + hi[i]) >>> 1;
        end
        // The exact sum, then one floor shift, equals the split form.
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + 128'(xform[j*3+i]) * mid[j];
            end
            comp[i] = clamp32((acc >>> FRAC_BITS) + 128'(xform[9+i]));
        end
        v = '{KIND_CENTER, comp[0], comp[1], comp[2], 1'b0};
        pending_vectors.push_back(v);
        for (int j = 0; j < 3; j++)
        begin
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                e = xform[j*3+i];
                sq = sq + e * e;
            end
            len[j] = floor_sqrt(sq[65:0]);
            for (int i = 0; i < 3; i++)
            begin
                e = xform[j*3+i];
                if (len[j] == 0)
                begin
                    comp[i] = (i == j) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
                end
                else
                begin
                    q = ((e < 0 ? -e : e) << FRAC_BITS) / len[j];
                    comp[i] = clamp32(e < 0 ? -$signed(q) : $signed(q));
                end
            end
            v = '{3'(KIND_AXIS0 + j), comp[0], comp[1], comp[2], 1'b0};
            pending_vectors.push_back(v);
        end
        for (int i = 0; i < 3; i++)
        begin
            d = hi[i] - lo[i];
            q = ((d < 0 ? -d : d) * len[i]) >> (FRAC_BITS + 1);
            comp[i] = clamp32(d < 0 ? -$signed(q) : $signed(q));
        end
        v = '{KIND_HALF, comp[0], comp[1], comp[2], 1'b1};
        pending_vectors.push_back(v);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h, expected %h (vector %0d)",
                 what, got, want, vectors_checked);
    endtask

    // Every accepted vector is compared with the oldest one predicted.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_vectors.size() == 0)
            begin
                report_mismatch("unexpected vector", 32'(res.vector_kind), 32'd0);
            end
            else
            begin
                want = pending_vectors.pop_front();
                if (res.vector_kind != want.vector_kind)
                    report_mismatch("vector_kind", 32'(res.vector_kind),
                                    32'(want.vector_kind));
                if (res.out_x != want.out_x)
                    report_mismatch("out_x", res.out_x, want.out_x);
                if (res.out_y != want.out_y)
                    report_mismatch("out_y", res.out_y, want.out_y);
                if (res.out_z != want.out_z)
                    report_mismatch("out_z", res.out_z, want.out_z);
                if (res.last_vector != want.last_vector)
                    report_mismatch("last_vector", 32'(res.last_vector),
                                    32'(want.last_vector));
            end
            vectors_checked++;
        end
    end

    // Send one request: optional idle cycles, then hold it until accepted.
    // Valid stays high after acceptance until the next request or an idle
    // cycle replaces it, which always happens before the next edge.
    // The prediction is made at acceptance so the store stays in order.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        if (r.opcode == OPC_LOAD)
        begin
            xform[r.column_index*3+0] = r.first_x;
            xform[r.column_index*3+1] = r.first_y;
            xform[r.column_index*3+2] = r.first_z;
        end
        else
        begin
            predict_box(r);
        end
        requests_sent++;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(131072))) - 32'sd65536;
            3: return $signed(32'($urandom_range(1 << 24))) - 32'sd8388608;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic load_column(input logic [1:0] col, input logic signed [31:0] x,
                               input logic signed [31:0] y, input logic signed [31:0] z);
        send_request('{OPC_LOAD, col, x, y, z, $signed($urandom()),
                       $signed($urandom()), $signed($urandom())});
    endtask

    task automatic convert_box(input logic signed [31:0] lx, input logic signed [31:0] ly,
                               input logic signed [31:0] lz, input logic signed [31:0] hx,
                               input logic signed [31:0] hy, input logic signed [31:0] hz);
        send_request('{OPC_CONVERT, 2'($urandom_range(3)), lx, ly, lz, hx, hy, hz});
    endtask

    // A never-loaded transform is all zero: unit axes, zero half sizes.
    task automatic test_zero_transform();
        convert_box(-32'sd65536, 32'sd0, 32'sd131072, 32'sd65536, 32'sd65536, 32'sd262144);
    endtask

    // Identity with a translation, a normal box, and an inverted box.
    task automatic test_identity_and_inverted();
        load_column(2'd0, 32'sd65536, 32'sd0, 32'sd0);
        load_column(2'd1, 32'sd0, 32'sd65536, 32'sd0);
        load_column(2'd2, 32'sd0, 32'sd0, 32'sd65536);
        load_column(2'd3, 32'sd327680, -32'sd131072, 32'sd1);
        convert_box(-32'sd131072, -32'sd65536, 32'sd0, 32'sd196608, 32'sd65536, 32'sd7);
        convert_box(32'sd196608, 32'sd65536, 32'sd7, -32'sd131072, -32'sd65536, 32'sd0);
    endtask

    // Full-scale words: the center and half-size paths saturate, and a single zero
    // column falls back to its unit axis while the others stay scaled.
    task automatic test_extremes();
        load_column(2'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        load_column(2'd1, 32'sd0, 32'sd0, 32'sd0);
        load_column(2'd2, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        load_column(2'd3, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
        convert_box(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        convert_box(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        load_column(2'd1, 32'sd1, -32'sd1, 32'sd0);
        convert_box(32'sh80000000, 32'sd0, -32'sd1, 32'sd0, 32'sh7FFFFFFF, 32'sd1);
    endtask

    // Random requests: one in four on average loads a random column, the rest
    // convert random boxes against whatever transform is loaded at the time.
    task automatic test_random(input int unsigned n);
        int unsigned sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(3) == 0)
            begin
                load_column(2'($urandom_range(3)), rand_word(), rand_word(), rand_word());
            end
            else
            begin
                convert_box(rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word(), rand_word());
            end
            sent++;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_vectors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 36;
        recv_idle_pct = 62;
        error_count = 0;
        vectors_checked = 0;
        requests_sent = 0;
        cycle_count = 0;
        for (int i = 0; i < 12; i++)
        begin
            xform[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_transform();
        test_identity_and_inverted();
        test_extremes();

        test_random(70);
        send_idle_pct = 62;
        recv_idle_pct = 36;
        test_random(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(70);
        drain();

        $display("Sent %0d requests (column loads and box conversions), checked %0d vectors,",
                 requests_sent, vectors_checked);
        $display("under three idle patterns, with %0d mismatches.", error_count);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
